// ----- rtl/quaternion_slerp_core_macros.svh -----
// ---------------------------------------------------------------------------
// quaternion_slerp_core_macros: assertion shorthands for the slerp checker
// Expects i_clk and i_rst_n in the scope of use.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_CORE_MACROS_SVH
`define QUATERNION_SLERP_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define QSLP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qslp check failed");

// next-cycle implication, off during reset
`define QSLP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qslp check failed");

// holds in the cycle after any cycle with reset asserted
`define QSLP_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("qslp reset check failed");

`endif

// ----- rtl/qslp_pkg.sv -----
// ---------------------------------------------------------------------------
// qslp_pkg: shared types and constants for the quaternion slerp core
// Item formats, per-chain stage records and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package qslp_pkg;

    localparam int ONE_Q14  = 16384;
    localparam int ONE_Q16  = 65536;
    localparam int SQ_W     = 31;   // sqrt remainder / root width
    localparam int SQ_STEPS = 16;   // one root bit per step
    localparam int VX_W     = 32;   // vectoring x/y
    localparam int RX_W     = 29;   // rotation x/y
    localparam int Z_W      = 28;   // Q24 angle, signed
    localparam int MAG_W    = 27;   // sine magnitude
    localparam int NUM_W    = 43;   // dividend and quotient width
    localparam int S_W      = 44;   // signed weight

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] a_w;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] b_w;
        logic        [16:0] amount;
    } t_slerp_in;

    typedef struct packed {
        logic signed [15:0] r_x;
        logic signed [15:0] r_y;
        logic signed [15:0] r_z;
        logic signed [15:0] r_w;
        logic               used_linear;
    } t_slerp_out;

    // data riding along each chain
    typedef struct packed {
        t_slerp_in   item;
        logic [14:0] c;
        logic        flip;
        logic        linear;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic signed [VX_W-1:0] x;
        logic signed [VX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_vec;

    typedef struct packed {
        logic signed [RX_W-1:0] x;
        logic signed [RX_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_rot_lane;

    typedef struct packed {
        t_rot_lane [2:0] lane;
    } t_rot;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [MAG_W-1:0] rem;
        logic [NUM_W-1:0] quo;
        logic             neg;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [1:0]  lane;
        logic [MAG_W-1:0] d;
    } t_div;

    // atan(2^-i) in Q24, rounded
    function automatic logic [23:0] f_atan(input int i);
        logic [23:0] v;
        case (i)
            0:  v = 24'd13176795;
            1:  v = 24'd7778716;
            2:  v = 24'd4110060;
            3:  v = 24'd2086331;
            4:  v = 24'd1047214;
            5:  v = 24'd524117;
            6:  v = 24'd262123;
            7:  v = 24'd131069;
            8:  v = 24'd65536;
            9:  v = 24'd32768;
            10: v = 24'd16384;
            11: v = 24'd8192;
            12: v = 24'd4096;
            13: v = 24'd2048;
            14: v = 24'd1024;
            15: v = 24'd512;
            16: v = 24'd256;
            17: v = 24'd128;
            18: v = 24'd64;
            19: v = 24'd32;
            20: v = 24'd16;
            21: v = 24'd8;
            22: v = 24'd4;
            23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/qslp_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// qslp_sqrt_cell: one step of the digit-by-digit integer square root
// Settles one root bit and passes the remainder to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qslp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qslp_pkg::t_side i_side,
    input  qslp_pkg::t_sqrt i_data,
    output logic           o_valid,
    output qslp_pkg::t_side o_side,
    output qslp_pkg::t_sqrt o_data
);
    import qslp_pkg::*;

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - STEP));

    logic            r_valid;
    t_side           r_side;
    t_sqrt           r_data;
    t_sqrt           n_data;
    logic [SQ_W-1:0] w_trial;

    always_comb begin
        n_data  = i_data;
        w_trial = i_data.root + BIT;
        if (i_data.v >= w_trial) begin
            n_data.v    = i_data.v - w_trial;
            n_data.root = (i_data.root >> 1) + BIT;
        end else begin
            n_data.root = i_data.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_data  = r_data;

endmodule

// ----- rtl/qslp_vec_cell.sv -----
// ---------------------------------------------------------------------------
// qslp_vec_cell: one CORDIC vectoring step
// Rotates (x, y) toward the x axis and accumulates the angle in Q24.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qslp_vec_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qslp_pkg::t_side i_side,
    input  qslp_pkg::t_vec  i_data,
    output logic           o_valid,
    output qslp_pkg::t_side o_side,
    output qslp_pkg::t_vec  o_data
);
    import qslp_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(f_atan(STEP));

    logic                   r_valid;
    t_side                  r_side;
    t_vec                   r_data;
    t_vec                   n_data;
    logic signed [VX_W-1:0] w_dx;
    logic signed [VX_W-1:0] w_dy;

    always_comb begin
        w_dx = i_data.y >>> STEP;
        w_dy = i_data.x >>> STEP;
        if (!i_data.y[VX_W-1]) begin
            n_data.x = i_data.x + w_dx;
            n_data.y = i_data.y - w_dy;
            n_data.z = i_data.z + ATAN;
        end else begin
            n_data.x = i_data.x - w_dx;
            n_data.y = i_data.y + w_dy;
            n_data.z = i_data.z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_data  = r_data;

endmodule

// ----- rtl/qslp_rot_cell.sv -----
// ---------------------------------------------------------------------------
// qslp_rot_cell: one CORDIC rotation step on three angle lanes
// Lanes carry omega, (1-t)*omega and t*omega; y ends as the scaled sine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qslp_rot_cell #(
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qslp_pkg::t_side i_side,
    input  qslp_pkg::t_rot  i_data,
    output logic           o_valid,
    output qslp_pkg::t_side o_side,
    output qslp_pkg::t_rot  o_data
);
    import qslp_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(f_atan(STEP));

    logic                   r_valid;
    t_side                  r_side;
    t_rot                   r_data;
    t_rot                   n_data;
    logic signed [RX_W-1:0] w_dx [3];
    logic signed [RX_W-1:0] w_dy [3];

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < 3; k++) begin
            w_dx[k] = i_data.lane[k].y >>> STEP;
            w_dy[k] = i_data.lane[k].x >>> STEP;
            if (!i_data.lane[k].z[Z_W-1]) begin
                n_data.lane[k].x = i_data.lane[k].x - w_dx[k];
                n_data.lane[k].y = i_data.lane[k].y + w_dy[k];
                n_data.lane[k].z = i_data.lane[k].z - ATAN;
            end else begin
                n_data.lane[k].x = i_data.lane[k].x + w_dx[k];
                n_data.lane[k].y = i_data.lane[k].y - w_dy[k];
                n_data.lane[k].z = i_data.lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_data  = r_data;

endmodule

// ----- rtl/qslp_div_cell.sv -----
// ---------------------------------------------------------------------------
// qslp_div_cell: one restoring division step on two lanes
// Both lanes share the divisor sin(omega); one quotient bit per cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module qslp_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  qslp_pkg::t_side i_side,
    input  qslp_pkg::t_div  i_data,
    output logic           o_valid,
    output qslp_pkg::t_side o_side,
    output qslp_pkg::t_div  o_data
);
    import qslp_pkg::*;

    logic             r_valid;
    t_side            r_side;
    t_div             r_data;
    t_div             n_data;
    logic [MAG_W:0]   w_part [2];
    logic             w_bit  [2];

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < 2; k++) begin
            w_part[k] = {i_data.lane[k].rem, i_data.lane[k].num[NUM_W-1]};
            if (w_part[k] >= {1'b0, i_data.d}) begin
                n_data.lane[k].rem = MAG_W'(w_part[k] - {1'b0, i_data.d});
                w_bit[k] = 1'b1;
            end else begin
                n_data.lane[k].rem = w_part[k][MAG_W-1:0];
                w_bit[k] = 1'b0;
            end
            n_data.lane[k].num = i_data.lane[k].num << 1;
            n_data.lane[k].quo = {i_data.lane[k].quo[NUM_W-2:0], w_bit[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_data  = r_data;

endmodule

// ----- rtl/quaternion_slerp_core.sv -----
// ---------------------------------------------------------------------------
// quaternion_slerp_core: pipelined fixed-point quaternion slerp
// Throughput: one item per cycle unless a held result stalls the pipeline;
// the 43-step divider chain sets the depth.
// Reset: synchronous, active low; clears pipeline valids, margin returns to 1.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module quaternion_slerp_core #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  qslp_pkg::t_slerp_in  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output qslp_pkg::t_slerp_out o_out_item,
    input  logic                 i_cfg_we,
    input  logic [14:0]          i_cfg_data
);
    import qslp_pkg::*;

    localparam int N = ANGLE_ITERATIONS;
    localparam logic [SQ_W-1:0] SQ_ONE = SQ_W'(1) << 28;

    function automatic logic signed [15:0] f_sat16(input logic signed [61:0] v);
        logic signed [15:0] r;
        if (v > 62'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -62'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic w_adv;
    logic [14:0] r_margin;

    // stage registers
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_m_valid, r_d_valid;
    logic r_w_valid, r_p_valid, r_q_valid, r_out_valid;

    t_slerp_in          r_s1_item, n_s1_item;
    logic signed [31:0] r_s1_prod [4];
    t_side              r_s2_side, n_s2_side;
    t_side              r_s3_side;
    t_sqrt              r_s3_data;
    t_side              r_m_side;
    t_rot               r_m_data, n_m_data;
    t_side              r_d_side, n_d_side;
    t_div               r_d_data, n_d_data;
    t_side              r_w_side;
    logic signed [S_W-1:0] r_w_s1, r_w_s2, n_w_s1, n_w_s2;
    t_side              r_p_side;
    logic signed [37:0] r_p_h1 [4];
    logic signed [37:0] r_p_h2 [4];
    logic signed [38:0] r_p_l1 [4];
    logic signed [38:0] r_p_l2 [4];
    t_side              r_q_side;
    logic signed [38:0] r_q_hi [4];
    logic signed [39:0] r_q_lo [4];
    t_slerp_out         r_out_item, n_out_item;

    // chains
    logic  w_sq_valid [SQ_STEPS+1];
    t_side w_sq_side  [SQ_STEPS+1];
    t_sqrt w_sq_data  [SQ_STEPS+1];
    logic  w_vec_valid [N+1];
    t_side w_vec_side  [N+1];
    t_vec  w_vec_data  [N+1];
    logic  w_rot_valid [N+1];
    t_side w_rot_side  [N+1];
    t_rot  w_rot_data  [N+1];
    logic  w_div_valid [NUM_W+1];
    t_side w_div_side  [NUM_W+1];
    t_div  w_div_data  [NUM_W+1];

    // stage-local combinational
    logic signed [33:0] w_dot;
    logic [32:0]        w_mag;
    logic [18:0]        w_cfull;
    logic [14:0]        w_c;
    logic [14:0]        w_margin;
    logic signed [16:0] w_thr;
    logic [29:0]        w_sq;
    logic [26:0]        w_omega;
    logic [16:0]        w_tc;
    logic [43:0]        w_at_full;
    logic [43:0]        w_a1_full;
    logic signed [RX_W-1:0] w_sin_y [2];
    logic signed [RX_W-1:0] w_sin_abs [2];
    logic [S_W-1:0]     w_q [2];
    logic signed [15:0] w_a [4];
    logic signed [15:0] w_b [4];
    logic signed [15:0] w_qa [4];
    logic signed [15:0] w_qb [4];
    logic signed [61:0] w_tot [4];
    logic signed [15:0] w_r [4];

    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= 15'd1;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_m_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_w_valid   <= 1'b0;
            r_p_valid   <= 1'b0;
            r_q_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_in_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_m_valid   <= w_vec_valid[N];
            r_d_valid   <= w_rot_valid[N];
            r_w_valid   <= w_div_valid[NUM_W];
            r_p_valid   <= r_w_valid;
            r_q_valid   <= r_p_valid;
            r_out_valid <= r_q_valid;
        end
    end

    // stage 1: saturate t, dot-product terms
    always_comb begin
        n_s1_item = i_in_item;
        if (i_in_item.amount > 17'(ONE_Q16)) begin
            n_s1_item.amount = 17'(ONE_Q16);
        end
    end

    // stage 2: |dot| in Q14, clamp, linear decision
    always_comb begin
        w_dot   = 34'(r_s1_prod[0]) + 34'(r_s1_prod[1]) + 34'(r_s1_prod[2])
                + 34'(r_s1_prod[3]);
        w_mag   = w_dot[33] ? 33'(-w_dot) : 33'(w_dot);
        w_cfull = w_mag[32:14];
        w_c     = (w_cfull > 19'(ONE_Q14)) ? 15'(ONE_Q14) : w_cfull[14:0];
        w_margin = (r_margin == 15'd0) ? 15'd1 : r_margin;
        w_thr   = 17'sd16384 - $signed({2'b00, w_margin});
        n_s2_side.item   = r_s1_item;
        n_s2_side.c      = w_c;
        n_s2_side.flip   = w_dot[33];
        n_s2_side.linear = $signed({2'b00, w_c}) > w_thr;
    end

    assign w_sq = 30'(r_s2_side.c) * 30'(r_s2_side.c);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_item    <= n_s1_item;
            r_s1_prod[0] <= 32'(i_in_item.a_x) * 32'(i_in_item.b_x);
            r_s1_prod[1] <= 32'(i_in_item.a_y) * 32'(i_in_item.b_y);
            r_s1_prod[2] <= 32'(i_in_item.a_z) * 32'(i_in_item.b_z);
            r_s1_prod[3] <= 32'(i_in_item.a_w) * 32'(i_in_item.b_w);
            r_s2_side    <= n_s2_side;
            r_s3_side    <= r_s2_side;
            r_s3_data.v    <= SQ_ONE - SQ_W'(w_sq);
            r_s3_data.root <= '0;
        end
    end

    // square root chain: s = isqrt(1 - c^2) in Q14
    assign w_sq_valid[0] = r_s3_valid;
    assign w_sq_side[0]  = r_s3_side;
    assign w_sq_data[0]  = r_s3_data;

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        qslp_sqrt_cell #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_sq_valid[g]),
            .i_side  (w_sq_side[g]),
            .i_data  (w_sq_data[g]),
            .o_valid (w_sq_valid[g+1]),
            .o_side  (w_sq_side[g+1]),
            .o_data  (w_sq_data[g+1])
        );
    end

    // vectoring chain: omega = angle of (c, s)
    assign w_vec_valid[0]  = w_sq_valid[SQ_STEPS];
    assign w_vec_side[0]   = w_sq_side[SQ_STEPS];
    assign w_vec_data[0].x = VX_W'(w_sq_side[SQ_STEPS].c) << 14;
    assign w_vec_data[0].y = VX_W'(w_sq_data[SQ_STEPS].root) << 14;
    assign w_vec_data[0].z = '0;

    for (genvar g = 0; g < N; g++) begin : g_vec
        qslp_vec_cell #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_vec_valid[g]),
            .i_side  (w_vec_side[g]),
            .i_data  (w_vec_data[g]),
            .o_valid (w_vec_valid[g+1]),
            .o_side  (w_vec_side[g+1]),
            .o_data  (w_vec_data[g+1])
        );
    end

    // angle split: omega, (1-t)*omega, t*omega
    always_comb begin
        w_omega   = w_vec_data[N].z[Z_W-1] ? 27'd0 : w_vec_data[N].z[26:0];
        w_tc      = 17'(ONE_Q16) - w_vec_side[N].item.amount;
        w_at_full = 44'(w_vec_side[N].item.amount) * 44'(w_omega);
        w_a1_full = 44'(w_tc) * 44'(w_omega);
        for (int k = 0; k < 3; k++) begin
            n_m_data.lane[k].x = RX_W'(1) << 26;
            n_m_data.lane[k].y = '0;
        end
        n_m_data.lane[0].z = $signed({1'b0, w_omega});
        n_m_data.lane[1].z = $signed(w_a1_full[43:16]);
        n_m_data.lane[2].z = $signed(w_at_full[43:16]);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_side <= w_vec_side[N];
            r_m_data <= n_m_data;
        end
    end

    // rotation chain: scaled sines
    assign w_rot_valid[0] = r_m_valid;
    assign w_rot_side[0]  = r_m_side;
    assign w_rot_data[0]  = r_m_data;

    for (genvar g = 0; g < N; g++) begin : g_rot
        qslp_rot_cell #(.STEP(g)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_rot_valid[g]),
            .i_side  (w_rot_side[g]),
            .i_data  (w_rot_data[g]),
            .o_valid (w_rot_valid[g+1]),
            .o_side  (w_rot_side[g+1]),
            .o_data  (w_rot_data[g+1])
        );
    end

    // divider setup; a non-positive sin(omega) falls back to linear weights
    always_comb begin
        n_d_side = w_rot_side[N];
        if (w_rot_data[N].lane[0].y[RX_W-1] || (w_rot_data[N].lane[0].y == '0)) begin
            n_d_side.linear = 1'b1;
        end
        n_d_data.d = w_rot_data[N].lane[0].y[MAG_W-1:0];
        for (int k = 0; k < 2; k++) begin
            w_sin_y[k]   = w_rot_data[N].lane[k+1].y;
            w_sin_abs[k] = w_sin_y[k][RX_W-1] ? -w_sin_y[k] : w_sin_y[k];
            n_d_data.lane[k].num = {w_sin_abs[k][MAG_W-1:0], 16'd0};
            n_d_data.lane[k].rem = '0;
            n_d_data.lane[k].quo = '0;
            n_d_data.lane[k].neg = w_sin_y[k][RX_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_side <= n_d_side;
            r_d_data <= n_d_data;
        end
    end

    assign w_div_valid[0] = r_d_valid;
    assign w_div_side[0]  = r_d_side;
    assign w_div_data[0]  = r_d_data;

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        qslp_div_cell u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_div_valid[g]),
            .i_side  (w_div_side[g]),
            .i_data  (w_div_data[g]),
            .o_valid (w_div_valid[g+1]),
            .o_side  (w_div_side[g+1]),
            .o_data  (w_div_data[g+1])
        );
    end

    // weights: quotient truncates toward zero, then linear and flip overrides
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_q[k] = {1'b0, w_div_data[NUM_W].lane[k].quo};
        end
        n_w_s1 = w_div_data[NUM_W].lane[0].neg ? -$signed(w_q[0]) : $signed(w_q[0]);
        n_w_s2 = w_div_data[NUM_W].lane[1].neg ? -$signed(w_q[1]) : $signed(w_q[1]);
        if (w_div_side[NUM_W].linear) begin
            n_w_s1 = $signed(S_W'(17'(ONE_Q16) - w_div_side[NUM_W].item.amount));
            n_w_s2 = $signed(S_W'(w_div_side[NUM_W].item.amount));
        end
        if (w_div_side[NUM_W].flip) begin
            n_w_s2 = -n_w_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w_side <= w_div_side[NUM_W];
            r_w_s1   <= n_w_s1;
            r_w_s2   <= n_w_s2;
        end
    end

    // blend: weights split in 22-bit halves per multiply
    always_comb begin
        w_a[0] = r_w_side.item.a_x;
        w_a[1] = r_w_side.item.a_y;
        w_a[2] = r_w_side.item.a_z;
        w_a[3] = r_w_side.item.a_w;
        w_b[0] = r_w_side.item.b_x;
        w_b[1] = r_w_side.item.b_y;
        w_b[2] = r_w_side.item.b_z;
        w_b[3] = r_w_side.item.b_w;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_side <= r_w_side;
            r_q_side <= r_p_side;
            for (int k = 0; k < 4; k++) begin
                r_p_h1[k] <= 38'($signed(r_w_s1[S_W-1:22])) * 38'(w_a[k]);
                r_p_l1[k] <= 39'($signed({1'b0, r_w_s1[21:0]})) * 39'(w_a[k]);
                r_p_h2[k] <= 38'($signed(r_w_s2[S_W-1:22])) * 38'(w_b[k]);
                r_p_l2[k] <= 39'($signed({1'b0, r_w_s2[21:0]})) * 39'(w_b[k]);
                r_q_hi[k] <= 39'(r_p_h1[k]) + 39'(r_p_h2[k]);
                r_q_lo[k] <= 40'(r_p_l1[k]) + 40'(r_p_l2[k]) + 40'sd32768;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_qa[k]  = '0;
            w_qb[k]  = '0;
            w_tot[k] = (62'(r_q_hi[k]) <<< 22) + 62'(r_q_lo[k]);
            w_r[k]   = f_sat16(w_tot[k] >>> 16);
        end
        n_out_item.r_x = w_r[0] | w_qa[0] | w_qb[0];
        n_out_item.r_y = w_r[1] | w_qa[1] | w_qb[1];
        n_out_item.r_z = w_r[2] | w_qa[2] | w_qb[2];
        n_out_item.r_w = w_r[3] | w_qa[3] | w_qb[3];
        n_out_item.used_linear = r_q_side.linear;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- rtl/qslp_checker.sv -----
// ---------------------------------------------------------------------------
// qslp_checker: port-level checks for quaternion_slerp_core
// Watches the item handshakes; bound to the core below.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "quaternion_slerp_core_macros.svh"
module qslp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input qslp_pkg::t_slerp_out o_out_item
);
    import qslp_pkg::*;

    // a held result keeps its payload
    `QSLP_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    // the input side stalls only behind a blocked result
    `QSLP_ASSERT_IMP(a_stall_src, 1'b1, o_in_stall == (o_out_valid && i_out_stall))
    // reset leaves no result valid
    `QSLP_ASSERT_RST(a_rst_empty, !o_out_valid)

endmodule

bind quaternion_slerp_core qslp_checker u_qslp_checker (.*);
